@@ rtl/bisect_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisect_pkg
// Shared types and codes for the bisection root search block.
// ----------------------------------------------------------------------------
package bisect_pkg;

  // search phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_LOWER,
    PH_WAIT_UPPER,
    PH_RUN,
    PH_DONE,
    PH_FAIL
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK,
    ST_LOWER_POS,
    ST_UPPER_NEG,
    ST_NOT_READY
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOWER_END,
    CFG_UPPER_END,
    CFG_X_TOL,
    CFG_F_TOL
  } cfg_index_t;

  // item kinds carried on the input tuser
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_VALUE = 1'b1;

  // flags that travel with each result
  typedef struct packed {
    logic    done_res;
    status_t status;
  } step_flags_t;

endpackage

@@ rtl/bisect_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisect_cfg
// Configuration registers: bracket ends and stop tolerances.
// ----------------------------------------------------------------------------
module bisect_cfg #(
  parameter int WORD_BITS     = 48,
  parameter int FRACTION_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] lower_end,
  output logic [WORD_BITS-1:0] upper_end,
  output logic [WORD_BITS-2:0] x_tolerance,
  output logic [WORD_BITS-2:0] f_tolerance
);

  // +-1e6 in the fixed point format, saturated to the word
  localparam logic [63:0] WPOS    = (64'd1 << (WORD_BITS - 1)) - 64'd1;
  localparam logic [63:0] BIG_RAW = 64'd1000000 << FRACTION_BITS;
  localparam logic [63:0] BIG     = (BIG_RAW > WPOS) ? WPOS : BIG_RAW;
  localparam logic [63:0] NEG_BIG = 64'd0 - BIG;
  // 1e-6 rounded to nearest, at least one lsb
  localparam logic [63:0] TOL_RAW = ((64'd1 << FRACTION_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] TOL     = (TOL_RAW == 64'd0) ? 64'd1 : TOL_RAW;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_end   <= NEG_BIG[WORD_BITS-1:0];
      upper_end   <= BIG[WORD_BITS-1:0];
      x_tolerance <= TOL[WORD_BITS-2:0];
      f_tolerance <= TOL[WORD_BITS-2:0];
    end else if (wr_en) begin
      case (bisect_pkg::cfg_index_t'(wr_index))
        bisect_pkg::CFG_LOWER_END: lower_end   <= wr_data;
        bisect_pkg::CFG_UPPER_END: upper_end   <= wr_data;
        bisect_pkg::CFG_X_TOL:     x_tolerance <= wr_data[WORD_BITS-2:0];
        bisect_pkg::CFG_F_TOL:     f_tolerance <= wr_data[WORD_BITS-2:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bisect_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisect_core
// Search state and the combinational step: order, update, stop test, midpoint.
// ----------------------------------------------------------------------------
module bisect_core #(
  parameter int WORD_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step_en,
  input  logic                    mode,
  input  logic [WORD_BITS-1:0]    fval,
  input  logic [WORD_BITS-1:0]    lower_end,
  input  logic [WORD_BITS-1:0]    upper_end,
  input  logic [WORD_BITS-2:0]    x_tolerance,
  input  logic [WORD_BITS-2:0]    f_tolerance,
  output logic [WORD_BITS-1:0]    x_value,
  output bisect_pkg::step_flags_t flags
);

  localparam int W = WORD_BITS;

  bisect_pkg::phase_t phase, phase_next;
  logic [W-1:0] end_a, end_b, value_a, value_b, probe_point, root_point;
  logic [W-1:0] end_a_next, end_b_next, value_a_next, value_b_next;
  logic [W-1:0] probe_point_next, root_point_next;

  logic         swap, run_neg, in_run;
  logic [W-1:0] ord_a, ord_b, ord_va, ord_vb;
  logic [W-1:0] run_a, run_b, run_va, run_vb;
  logic [W-1:0] adv_a, adv_b, adv_va, adv_vb;
  logic [W:0]   dx, df, adx, adf, sum;
  logic [W-1:0] mid;
  logic         stop;

  // ordering of the first two samples so that f(a) <= f(b)
  assign swap   = $signed(fval) < $signed(value_a);
  assign ord_a  = swap ? end_b : end_a;
  assign ord_b  = swap ? end_a : end_b;
  assign ord_va = swap ? fval : value_a;
  assign ord_vb = swap ? value_a : fval;

  // running update: replace the end whose value has the sign of f
  assign run_neg = fval[W-1];
  assign run_a   = run_neg ? probe_point : end_a;
  assign run_va  = run_neg ? fval : value_a;
  assign run_b   = run_neg ? end_b : probe_point;
  assign run_vb  = run_neg ? value_b : fval;

  assign in_run = (phase == bisect_pkg::PH_RUN);
  assign adv_a  = in_run ? run_a : ord_a;
  assign adv_b  = in_run ? run_b : ord_b;
  assign adv_va = in_run ? run_va : ord_va;
  assign adv_vb = in_run ? run_vb : ord_vb;

  // exact differences and midpoint on one extra bit
  assign dx  = {adv_b[W-1], adv_b} - {adv_a[W-1], adv_a};
  assign df  = {adv_vb[W-1], adv_vb} - {adv_va[W-1], adv_va};
  assign adx = dx[W] ? -dx : dx;
  assign adf = df[W] ? -df : df;
  assign sum = {adv_a[W-1], adv_a} + {adv_b[W-1], adv_b};
  assign mid = sum[W:1];  // floor of the half sum
  assign stop = (adx < {2'b00, x_tolerance}) || (adf < {2'b00, f_tolerance});

  always_comb begin
    phase_next       = phase;
    end_a_next       = end_a;
    end_b_next       = end_b;
    value_a_next     = value_a;
    value_b_next     = value_b;
    probe_point_next = probe_point;
    root_point_next  = root_point;
    x_value          = '0;
    flags.done_res   = 1'b0;
    flags.status     = bisect_pkg::ST_NOT_READY;

    if (mode == bisect_pkg::MODE_START) begin
      end_a_next       = lower_end;
      end_b_next       = upper_end;
      probe_point_next = lower_end;
      phase_next       = bisect_pkg::PH_WAIT_LOWER;
      x_value          = lower_end;
      flags.status     = bisect_pkg::ST_OK;
    end else begin
      case (phase)
        bisect_pkg::PH_WAIT_LOWER: begin
          value_a_next     = fval;
          probe_point_next = end_b;
          phase_next       = bisect_pkg::PH_WAIT_UPPER;
          x_value          = end_b;
          flags.status     = bisect_pkg::ST_OK;
        end
        bisect_pkg::PH_WAIT_UPPER, bisect_pkg::PH_RUN: begin
          if (in_run && fval == '0) begin
            // exact zero: the probe is the root
            end_a_next      = probe_point;
            end_b_next      = probe_point;
            value_a_next    = '0;
            value_b_next    = '0;
            root_point_next = probe_point;
            phase_next      = bisect_pkg::PH_DONE;
            x_value         = probe_point;
            flags.done_res  = 1'b1;
            flags.status    = bisect_pkg::ST_OK;
          end else begin
            end_a_next   = adv_a;
            end_b_next   = adv_b;
            value_a_next = adv_va;
            value_b_next = adv_vb;
            if (!in_run && !adv_va[W-1] && adv_va != '0) begin
              phase_next   = bisect_pkg::PH_FAIL;
              x_value      = adv_a;
              flags.status = bisect_pkg::ST_LOWER_POS;
            end else if (!in_run && adv_vb[W-1]) begin
              phase_next   = bisect_pkg::PH_FAIL;
              x_value      = adv_b;
              flags.status = bisect_pkg::ST_UPPER_NEG;
            end else if (stop) begin
              root_point_next = mid;
              phase_next      = bisect_pkg::PH_DONE;
              x_value         = mid;
              flags.done_res  = 1'b1;
              flags.status    = bisect_pkg::ST_OK;
            end else begin
              probe_point_next = mid;
              phase_next       = bisect_pkg::PH_RUN;
              x_value          = mid;
              flags.status     = bisect_pkg::ST_OK;
            end
          end
        end
        bisect_pkg::PH_DONE: begin
          x_value        = root_point;
          flags.done_res = 1'b1;
          flags.status   = bisect_pkg::ST_OK;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bisect_pkg::PH_IDLE;
    end else if (step_en) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_a       <= '0;
      end_b       <= '0;
      value_a     <= '0;
      value_b     <= '0;
      probe_point <= '0;
      root_point  <= '0;
    end else if (step_en) begin
      end_a       <= end_a_next;
      end_b       <= end_b_next;
      value_a     <= value_a_next;
      value_b     <= value_b_next;
      probe_point <= probe_point_next;
      root_point  <= root_point_next;
    end
  end

endmodule

@@ rtl/bisection_root_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisection_root_search_top
// Bisection root search over sampled function values, signed fixed point.
// ----------------------------------------------------------------------------
// Send a start beat (tuser 0) to load the bracket from the configuration
// registers; the block answers with the lower end as the first probe. Answer
// every probe with a value beat (tuser 1) carrying f at that probe in tdata.
// Each input beat yields exactly one output beat: the next probe, or the root
// with done flagged, or an error status when the first two samples do not
// bracket a zero (the block then stays failed until the next start). The step
// is one registered pass: an input register, combinational compare, subtract
// and halve logic against the search state, and an output register; one beat
// per cycle is sustained while the sink keeps m_axis_tready high. The input
// register doubles as a skid stage, so a new beat is taken while a result
// waits on the master side. Write configuration only while no beat is in
// flight.
// ----------------------------------------------------------------------------
module bisection_root_search_top #(
  parameter int WORD_BITS     = 48,
  parameter int FRACTION_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0]        s_axis_tdata,  // function_value
  input  logic                                  s_axis_tuser,  // mode
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]        m_axis_tdata,  // x_value
  output logic [2:0]                            m_axis_tuser,  // status, done_res
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [WORD_BITS-1:0]                  cfg_data
);

  localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

  logic [WORD_BITS-1:0] lower_end, upper_end;
  logic [WORD_BITS-2:0] x_tolerance, f_tolerance;

  // input register / skid stage
  logic                 in_valid;
  logic                 in_mode;
  logic [WORD_BITS-1:0] in_fval;

  // output register
  logic                    out_valid;
  logic [WORD_BITS-1:0]    out_x;
  bisect_pkg::step_flags_t out_flags;

  logic                    step_en;
  logic [WORD_BITS-1:0]    step_x;
  bisect_pkg::step_flags_t step_flags;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  bisect_cfg #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .lower_end   (lower_end),
    .upper_end   (upper_end),
    .x_tolerance (x_tolerance),
    .f_tolerance (f_tolerance)
  );

  // advance a held beat whenever the output register is free or draining
  assign step_en       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode <= s_axis_tuser;
      in_fval <= s_axis_tdata[WORD_BITS-1:0];
    end
  end

  bisect_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (step_en),
    .mode        (in_mode),
    .fval        (in_fval),
    .lower_end   (lower_end),
    .upper_end   (upper_end),
    .x_tolerance (x_tolerance),
    .f_tolerance (f_tolerance),
    .x_value     (step_x),
    .flags       (step_flags)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_x     <= step_x;
      out_flags <= step_flags;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_BITS'(out_x);
  assign m_axis_tuser  = {out_flags.status, out_flags.done_res};

endmodule
